@@ design/rpat_pkg.sv @@
// shared constants, types and distance rom for the rssi proximity alert trigger
package rpat_pkg;

   // window geometry
   localparam int WINDOW_DEPTH = 8;
   localparam int HALF_DEPTH   = WINDOW_DEPTH / 2;
   localparam int PTR_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W        = $clog2(WINDOW_DEPTH) + 9;
   localparam int MAG_W        = SUM_W - 1;
   localparam int BIT_W        = $clog2(MAG_W);

   // field widths
   localparam int RSSI_W  = 8;
   localparam int TIME_W  = 32;
   localparam int DIST_W  = 20;
   localparam int CM_W    = 16;
   localparam int CONF_W  = 4;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // distance rom: one entry per negative average, indexed by -avg-1
   localparam int ROM_W     = 23;
   localparam int ROM_DEPTH = 128;
   localparam int ROM_IDX_W = $clog2(ROM_DEPTH);
   localparam logic [ROM_W-1:0] CONTACT_OFFSET = ROM_W'(16);
   localparam longint unsigned DIST_SCALE = 64'd10000000000;
   localparam longint unsigned DIST_ROUND = 64'd5000000000;
   localparam longint unsigned DIST_GAIN  = 64'd1600;

   typedef longint unsigned frac_tab_type [18];
   typedef longint unsigned ten_tab_type [8];
   typedef logic [ROM_W-1:0] dist_rom_type [ROM_DEPTH];

   localparam frac_tab_type POW_FRAC = '{
      64'd1000000, 64'd1136464, 64'd1291550, 64'd1467799, 64'd1668101, 64'd1895736,
      64'd2154435, 64'd2448437, 64'd2782559, 64'd3162278, 64'd3593814, 64'd4084239,
      64'd4641589, 64'd5274997, 64'd5994843, 64'd6812921, 64'd7742637, 64'd8799226
   };
   localparam ten_tab_type POW_TEN = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000, 64'd10000000
   };

   // log-distance law, worked out at elaboration
   function automatic dist_rom_type build_dist_rom();
      dist_rom_type rom;
      longint unsigned v;
      int m;
      int e;
      int j;
      for (int idx = 0; idx < ROM_DEPTH; idx++) begin
         m = idx + 8;
         e = m / 18;
         j = m % 18;
         if (e > 7) begin
            e = 7;
         end
         v = (DIST_GAIN * POW_FRAC[j] * POW_TEN[e] + DIST_ROUND) / DIST_SCALE;
         rom[idx] = v[ROM_W-1:0];
      end
      return rom;
   endfunction

   localparam dist_rom_type DIST_ROM = build_dist_rom();

   // confidence thresholds and levels
   localparam logic signed [RSSI_W-1:0] CONF_T10 = -8'sd30;
   localparam logic signed [RSSI_W-1:0] CONF_T8  = -8'sd60;
   localparam logic signed [RSSI_W-1:0] CONF_T6  = -8'sd80;
   localparam logic signed [RSSI_W-1:0] CONF_T3  = -8'sd90;
   localparam logic [CONF_W-1:0] CONF_LVL10 = 4'd10;
   localparam logic [CONF_W-1:0] CONF_LVL8  = 4'd8;
   localparam logic [CONF_W-1:0] CONF_LVL6  = 4'd6;
   localparam logic [CONF_W-1:0] CONF_LVL3  = 4'd3;
   localparam logic [CONF_W-1:0] CONF_LVL1  = 4'd1;

   // commands and alert modes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_EVAL   = 1'b1;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIGGER_DIST = 3'd0,
      CSR_DELAY_EN     = 3'd1,
      CSR_DWELL        = 3'd2,
      CSR_COOLDOWN     = 3'd3,
      CSR_DURATION     = 3'd4,
      CSR_MODE         = 3'd5,
      CSR_MAX_DIST     = 3'd6
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROM,
      ST_CLAMP,
      ST_RANGE,
      ST_COOL,
      ST_START,
      ST_END,
      ST_RESP
   } state_type;

endpackage

@@ design/rpat_chan_if.sv @@
// request and response channel interfaces
interface rpat_req_if;
   logic                             valid;
   logic                             ready;
   logic                             cmd;
   logic signed [rpat_pkg::RSSI_W-1:0] rssi_dbm;
   logic [rpat_pkg::TIME_W-1:0]      now_ms;

   modport source (output valid, cmd, rssi_dbm, now_ms, input ready);
   modport sink   (input valid, cmd, rssi_dbm, now_ms, output ready);
endinterface

interface rpat_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rpat_pkg::RSSI_W-1:0] filtered_rssi;
   logic [rpat_pkg::DIST_W-1:0]        distance_sixteenths;
   logic [rpat_pkg::CONF_W-1:0]        confidence_tenths;
   logic                               enough_samples;
   logic                               in_range;
   logic                               alert_start;
   logic [rpat_pkg::MODE_W-1:0]        alert_drive;
   logic                               alert_on;

   modport source (output valid, filtered_rssi, distance_sixteenths, confidence_tenths,
                   enough_samples, in_range, alert_start, alert_drive, alert_on,
                   input ready);
   modport sink   (input valid, filtered_rssi, distance_sixteenths, confidence_tenths,
                   enough_samples, in_range, alert_start, alert_drive, alert_on,
                   output ready);
endinterface

@@ design/rssi_proximity_alert_trigger.sv @@
// rssi proximity alert trigger: moving average, distance lookup and alert sequencer
//
//  channel  | direction | contents
//  req_ch   | in        | cmd, rssi_dbm, now_ms (valid/ready)
//  rsp_ch   | out       | filtered_rssi .. alert_on, one per request (valid/ready)
//  csr_*    | in        | write enable, register index, 32-bit write data
//
// a sample request passes through the window update, the divider load, the bit-serial
// divider for the average (one quotient bit a cycle), the distance rom and the clamp.
// an evaluate request passes through the range, cooldown, start and end checks; its
// three time checks share one subtract/compare.
// one request at a time: req_ch.ready is high only while idle.
// the response is held until rsp_ch.ready; synchronous active-high reset.
module rssi_proximity_alert_trigger (
   input  logic                            clock,
   input  logic                            reset,
   rpat_req_if.sink                        req_ch,
   rpat_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [rpat_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpat_pkg::CSR_DATA_W-1:0] csr_data
);
   import rpat_pkg::*;

   state_type state_ff, state_in;

   // configuration registers
   logic [CM_W-1:0]   trig_dist_ff, trig_dist_in;
   logic              delay_en_ff, delay_en_in;
   logic [TIME_W-1:0] dwell_ff, dwell_in;
   logic [TIME_W-1:0] cooldown_ff, cooldown_in;
   logic [TIME_W-1:0] duration_ff, duration_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CM_W-1:0]   max_dist_ff, max_dist_in;

   // latched request
   logic signed [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [TIME_W-1:0]        now_ff, now_in;

   // sample window
   logic signed [RSSI_W-1:0] ring [WINDOW_DEPTH];
   logic signed [RSSI_W-1:0] old_ff;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   // divider
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;

   // beacon and alert state
   logic signed [RSSI_W-1:0] avg_ff, avg_in;
   logic [ROM_W-1:0]         rom_ff, rom_in;
   logic [DIST_W-1:0]        latest_ff, latest_in;
   logic                     seen_ff, seen_in;
   logic                     range_ff, range_in;
   logic [TIME_W-1:0]        range_start_ff, range_start_in;
   logic [TIME_W-1:0]        last_start_ff, last_start_in;
   logic                     alert_ff, alert_in;
   logic                     cool_ok_ff, cool_ok_in;
   logic                     skip_ff, skip_in;
   logic                     start_ff, start_in;
   logic [MODE_W-1:0]        drive_ff, drive_in;

   // shared time unit
   logic [TIME_W-1:0] t_opa, t_opb, t_diff;
   logic              t_ge;

   // combinational helpers
   logic [PTR_W:0]           wp_inc;
   logic signed [SUM_W-1:0]  rssi_ext, old_ext;
   logic [SUM_W-1:0]         sum_neg, mag_full;
   logic [CNT_W:0]           div_shift, div_diff;
   logic                     div_take;
   logic [MAG_W-1:0]         quo_next, quo_neg;
   logic [ROM_W-1:0]         rom_off;
   logic [DIST_W-1:0]        dist_cap;
   logic                     near;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // response payload straight from the state registers
   assign rsp_ch.valid               = (state_ff == ST_RESP);
   assign rsp_ch.filtered_rssi       = avg_ff;
   assign rsp_ch.distance_sixteenths = latest_ff;
   assign rsp_ch.enough_samples      = (count_ff >= CNT_W'(HALF_DEPTH));
   assign rsp_ch.in_range            = range_ff;
   assign rsp_ch.alert_start         = start_ff;
   assign rsp_ch.alert_drive         = drive_ff;
   assign rsp_ch.alert_on            = alert_ff;

   // confidence from the average
   always_comb begin
      if (avg_ff >= CONF_T10) begin
         rsp_ch.confidence_tenths = CONF_LVL10;
      end else if (avg_ff >= CONF_T8) begin
         rsp_ch.confidence_tenths = CONF_LVL8;
      end else if (avg_ff >= CONF_T6) begin
         rsp_ch.confidence_tenths = CONF_LVL6;
      end else if (avg_ff >= CONF_T3) begin
         rsp_ch.confidence_tenths = CONF_LVL3;
      end else begin
         rsp_ch.confidence_tenths = CONF_LVL1;
      end
   end

   // shared wrapping subtract and compare for the time checks
   always_comb begin
      case (state_ff)
         ST_COOL: begin
            t_opa = last_start_ff;
            t_opb = cooldown_ff;
         end
         ST_START: begin
            t_opa = range_start_ff;
            t_opb = dwell_ff;
         end
         ST_END: begin
            t_opa = last_start_ff;
            t_opb = duration_ff;
         end
         default: begin
            t_opa = last_start_ff;
            t_opb = duration_ff;
         end
      endcase
   end
   assign t_diff = now_ff - t_opa;
   assign t_ge   = (t_diff >= t_opb);

   // datapath helpers
   assign wp_inc    = {1'b0, wp_ff} + (PTR_W+1)'(1);
   assign rssi_ext  = {{(SUM_W-RSSI_W){rssi_ff[RSSI_W-1]}}, rssi_ff};
   assign old_ext   = {{(SUM_W-RSSI_W){old_ff[RSSI_W-1]}}, old_ff};
   assign sum_neg   = -sum_ff;
   assign mag_full  = sum_ff[SUM_W-1] ? sum_neg : sum_ff;
   assign div_shift = {rem_ff, quo_ff[MAG_W-1]};
   assign div_diff  = div_shift - {1'b0, count_ff};
   assign div_take  = (div_shift >= {1'b0, count_ff});
   assign quo_next  = {quo_ff[MAG_W-2:0], div_take};
   assign quo_neg   = -quo_next;
   assign rom_off   = (rom_ff > CONTACT_OFFSET) ? (rom_ff - CONTACT_OFFSET) : '0;
   assign dist_cap  = {max_dist_ff, 4'b0000};
   assign near      = seen_ff && (latest_ff <= {trig_dist_ff, 4'b0000});

   // sequencer: next state and next register values
   always_comb begin
      state_in       = state_ff;
      trig_dist_in   = trig_dist_ff;
      delay_en_in    = delay_en_ff;
      dwell_in       = dwell_ff;
      cooldown_in    = cooldown_ff;
      duration_in    = duration_ff;
      mode_in        = mode_ff;
      max_dist_in    = max_dist_ff;
      rssi_in        = rssi_ff;
      now_in         = now_ff;
      wp_in          = wp_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      neg_in         = neg_ff;
      bit_in         = bit_ff;
      avg_in         = avg_ff;
      rom_in         = rom_ff;
      latest_in      = latest_ff;
      seen_in        = seen_ff;
      range_in       = range_ff;
      range_start_in = range_start_ff;
      last_start_in  = last_start_ff;
      alert_in       = alert_ff;
      cool_ok_in     = cool_ok_ff;
      skip_in        = skip_ff;
      start_in       = start_ff;
      drive_in       = drive_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_DIST: trig_dist_in = csr_data[CM_W-1:0];
            CSR_DELAY_EN:     delay_en_in  = csr_data[0];
            CSR_DWELL:        dwell_in     = csr_data[TIME_W-1:0];
            CSR_COOLDOWN:     cooldown_in  = csr_data[TIME_W-1:0];
            CSR_DURATION:     duration_in  = csr_data[TIME_W-1:0];
            CSR_MODE:         mode_in      = csr_data[MODE_W-1:0];
            CSR_MAX_DIST:     max_dist_in  = csr_data[CM_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               rssi_in  = req_ch.rssi_dbm;
               now_in   = req_ch.now_ms;
               start_in = 1'b0;
               drive_in = '0;
               skip_in  = 1'b0;
               state_in = (req_ch.cmd == CMD_EVAL) ? ST_RANGE : ST_SUM;
            end
         end
         // window update, oldest sample read the cycle before
         ST_SUM: begin
            if (count_ff >= CNT_W'(WINDOW_DEPTH)) begin
               sum_in = sum_ff - old_ext + rssi_ext;
            end else begin
               sum_in   = sum_ff + rssi_ext;
               count_in = count_ff + CNT_W'(1);
            end
            wp_in    = (wp_inc >= (PTR_W+1)'(WINDOW_DEPTH)) ? '0 : wp_inc[PTR_W-1:0];
            seen_in  = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            neg_in   = sum_ff[SUM_W-1];
            quo_in   = mag_full[MAG_W-1:0];
            rem_in   = '0;
            bit_in   = BIT_W'(MAG_W - 1);
            state_in = ST_DIV;
         end
         // restoring divide of the sum magnitude by the count
         ST_DIV: begin
            rem_in = div_take ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            quo_in = quo_next;
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               avg_in   = neg_ff ? quo_neg[RSSI_W-1:0] : quo_next[RSSI_W-1:0];
               state_in = ST_ROM;
            end
         end
         ST_ROM: begin
            rom_in   = avg_ff[RSSI_W-1] ? DIST_ROM[~avg_ff[ROM_IDX_W-1:0]] : '0;
            state_in = ST_CLAMP;
         end
         // contact offset and saturation
         ST_CLAMP: begin
            latest_in = (rom_off > ROM_W'(dist_cap)) ? dist_cap : rom_off[DIST_W-1:0];
            state_in  = ST_RESP;
         end
         // range entry and exit
         ST_RANGE: begin
            if (near && !range_ff) begin
               range_in       = 1'b1;
               range_start_in = now_ff;
            end else if (!near && range_ff) begin
               range_in       = 1'b0;
               range_start_in = '0;
            end
            state_in = ST_COOL;
         end
         ST_COOL: begin
            cool_ok_in = t_ge;
            state_in   = ST_START;
         end
         // alert start after cooldown and optional dwell
         ST_START: begin
            if (range_ff && !alert_ff && cool_ok_ff && (!delay_en_ff || t_ge)) begin
               alert_in      = 1'b1;
               last_start_in = now_ff;
               if (mode_ff == MODE_NONE) begin
                  skip_in = 1'b1;
               end else begin
                  start_in = 1'b1;
                  drive_in = mode_ff;
               end
            end
            state_in = ST_END;
         end
         // alert end after duration
         ST_END: begin
            if (!skip_ff && alert_ff && t_ge) begin
               alert_in = 1'b0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sample ring: write on window update, registered read at the write pointer
   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         ring[wp_ff] <= rssi_ff;
      end
      old_ff <= ring[wp_ff];
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         trig_dist_ff   <= CM_W'(200);
         delay_en_ff    <= 1'b0;
         dwell_ff       <= '0;
         cooldown_ff    <= '0;
         duration_ff    <= TIME_W'(5000);
         mode_ff        <= '0;
         max_dist_ff    <= CM_W'(1000);
         wp_ff          <= '0;
         count_ff       <= '0;
         sum_ff         <= '0;
         avg_ff         <= '0;
         latest_ff      <= '0;
         seen_ff        <= 1'b0;
         range_ff       <= 1'b0;
         range_start_ff <= '0;
         last_start_ff  <= '0;
         alert_ff       <= 1'b0;
         start_ff       <= 1'b0;
         drive_ff       <= '0;
         skip_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         trig_dist_ff   <= trig_dist_in;
         delay_en_ff    <= delay_en_in;
         dwell_ff       <= dwell_in;
         cooldown_ff    <= cooldown_in;
         duration_ff    <= duration_in;
         mode_ff        <= mode_in;
         max_dist_ff    <= max_dist_in;
         wp_ff          <= wp_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         avg_ff         <= avg_in;
         latest_ff      <= latest_in;
         seen_ff        <= seen_in;
         range_ff       <= range_in;
         range_start_ff <= range_start_in;
         last_start_ff  <= last_start_in;
         alert_ff       <= alert_in;
         start_ff       <= start_in;
         drive_ff       <= drive_in;
         skip_ff        <= skip_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rssi_ff    <= rssi_in;
      now_ff     <= now_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      bit_ff     <= bit_in;
      rom_ff     <= rom_in;
      cool_ok_ff <= cool_ok_in;
   end

endmodule
